// ===== rtl/core/srtf_pkg.sv =====
// Shared constants, codes and word types of the shortest-remaining-time scheduler.
`default_nettype none

package srtf_pkg;

   // default sizing
   localparam int MAX_PROCS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 16;

   // fixed field widths
   localparam int ID_W      = 4;
   localparam int BURST_W   = 16;
   localparam int OUT_CNT_W = 16;
   localparam int REQ_W     = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ARRIVAL = 2'd0;
   localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_STATS   = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [ID_W-1:0]    proc_id;
      logic [BURST_W-1:0] burst_length;
   } req_word_type;

   typedef struct packed {
      logic [ID_W-1:0]      running_id;
      logic                 idle;
      logic                 newly_selected;
      logic                 finished;
      logic                 rejected;
      logic [OUT_CNT_W-1:0] wait_count;
      logic [OUT_CNT_W-1:0] turnaround_count;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic load_cand;
      logic reduce;
      logic exec_op;
      logic apply_tick;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_is_tick;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/srtf_chan_if.sv =====
// Valid/ready channel carrying one word of a given type.
`default_nettype none

interface srtf_chan_if #(
   parameter type word_type = logic
) ();
   logic     valid;
   logic     ready;
   word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/shortest_remaining_time_scheduler_core.sv =====
// Top level of the shortest-remaining-time-first scheduler.
//
//   channel   modport  word           role
//   req_chan  sink     req_word_type  arrival, tick or statistics read
//   rsp_chan  source   rsp_word_type  one result word per request
//
// Arrival and statistics read: the request is registered at accept and its result is loaded in EXEC.
// Tick: leaf candidates are loaded at accept, the search tree folds one level per cycle in SCAN,
// and the result is loaded in APPLY.
// One request is in flight at a time; a new one is accepted while a result waits.
// A stalled result port holds the finished request before its result load.
// Reset is synchronous: clears slot present bits, the last-runner mark, controller state and response valid.
`default_nettype none

module shortest_remaining_time_scheduler_core #(
   parameter int MAX_PROCS  = srtf_pkg::MAX_PROCS_DEF,
   parameter int COUNT_BITS = srtf_pkg::COUNT_BITS_DEF
) (
   input wire logic     clock,
   input wire logic     reset,
   srtf_chan_if.sink    req_chan,
   srtf_chan_if.source  rsp_chan
);

   srtf_pkg::ctrl_cmd_type    cmd;
   srtf_pkg::ctrl_status_type status;
   srtf_pkg::req_word_type    req_word;
   srtf_pkg::rsp_word_type    rsp_word;
   logic                      req_ready;
   logic                      rsp_valid;

   assign req_word         = req_chan.payload;
   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_word;

   srtf_ctrl #(
      .MAX_PROCS (MAX_PROCS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   srtf_dpath #(
      .MAX_PROCS  (MAX_PROCS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire

// ===== rtl/core/srtf_ctrl.sv =====
// Scheduler controller: request sequencing, search level count, response valid.
`default_nettype none

module srtf_ctrl #(
   parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire srtf_pkg::ctrl_status_type status,
   output srtf_pkg::ctrl_cmd_type        cmd
);

   localparam int Levels = $clog2(MAX_PROCS);
   localparam int CntW   = $clog2(Levels + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_APPLY = 2'd3;

   logic [1:0]      state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;
   logic            accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // sequence one request at a time
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               if (status.in_is_tick) begin
                  cmd.load_cand = 1'b1;
                  cnt_in        = CntW'(Levels - 1);
                  state_in      = S_SCAN;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_SCAN: begin
            cmd.reduce = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_APPLY;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.exec_op = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_APPLY: begin
            if (out_free) begin
               cmd.apply_tick = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // set on a new word, drop once taken
   always_comb begin
      priority if (cmd.exec_op || cmd.apply_tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted word did not start processing");

   a_rsp_from_command: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.exec_op || cmd.apply_tick))
      else $error("response valid rose without a result load");

   a_scan_exclusive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (!req_ready && !cmd.exec_op && !cmd.apply_tick))
      else $error("search overlaps accept or result load");

   a_cand_with_req: assert property (@(posedge clock) disable iff (reset)
      cmd.load_cand |-> (cmd.load_req && status.in_is_tick))
      else $error("candidate load outside a tick accept");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/srtf_dpath.sv =====
// Scheduler datapath: process slots, minimum-search tree, result register.
`default_nettype none

module srtf_dpath #(
   parameter int MAX_PROCS  = srtf_pkg::MAX_PROCS_DEF,
   parameter int COUNT_BITS = srtf_pkg::COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire srtf_pkg::req_word_type req_word,
   input  wire srtf_pkg::ctrl_cmd_type cmd,
   output srtf_pkg::ctrl_status_type  status,
   output srtf_pkg::rsp_word_type     rsp_word
);

   localparam int IdxW = $clog2(MAX_PROCS);
   localparam int Pow  = 1 << IdxW;
   localparam int BW   = srtf_pkg::BURST_W;
   localparam int OW   = srtf_pkg::OUT_CNT_W;
   localparam logic [31:0] OutMax = 32'((64'd1 << OW) - 64'd1);

   // slot lanes
   logic                  present_ff [MAX_PROCS];
   logic                  present_in [MAX_PROCS];
   logic [BW-1:0]         remain_ff  [MAX_PROCS];
   logic [BW-1:0]         remain_in  [MAX_PROCS];
   logic [COUNT_BITS-1:0] wait_ff    [MAX_PROCS];
   logic [COUNT_BITS-1:0] wait_in    [MAX_PROCS];
   logic [COUNT_BITS-1:0] turn_ff    [MAX_PROCS];
   logic [COUNT_BITS-1:0] turn_in    [MAX_PROCS];

   // search tree candidates
   logic            cv_ff [Pow];
   logic            cv_in [Pow];
   logic [BW-1:0]   ck_ff [Pow];
   logic [BW-1:0]   ck_in [Pow];
   logic [IdxW-1:0] ci_ff [Pow];
   logic [IdxW-1:0] ci_in [Pow];

   srtf_pkg::req_word_type req_ff;
   srtf_pkg::rsp_word_type rsp_ff, rsp_in;
   logic            last_valid_ff, last_valid_in;
   logic [IdxW-1:0] last_id_ff, last_id_in;

   logic            in_range;
   logic [IdxW-1:0] slot;
   logic            slot_present;
   logic [31:0]     wait_wide;
   logic [31:0]     turn_wide;

   assign status.in_is_tick = (req_word.req_type == srtf_pkg::REQ_TICK);
   assign rsp_word          = rsp_ff;

   assign in_range     = (32'(req_ff.proc_id) < 32'(MAX_PROCS));
   assign slot         = IdxW'(req_ff.proc_id);
   assign slot_present = in_range && present_ff[slot];
   assign wait_wide    = 32'(wait_ff[slot]);
   assign turn_wide    = 32'(turn_ff[slot]);

   // load leaves or fold one tree level; lower index wins ties
   always_comb begin
      for (int i = 0; i < Pow; i++) begin
         cv_in[i] = cv_ff[i];
         ck_in[i] = ck_ff[i];
         ci_in[i] = ci_ff[i];
      end
      if (cmd.load_cand) begin
         for (int i = 0; i < Pow; i++) begin
            ci_in[i] = IdxW'(i);
            if (i < MAX_PROCS) begin
               cv_in[i] = present_ff[i] && (remain_ff[i] != '0);
               ck_in[i] = remain_ff[i];
            end else begin
               cv_in[i] = 1'b0;
               ck_in[i] = '0;
            end
         end
      end else if (cmd.reduce) begin
         for (int i = 0; i < Pow / 2; i++) begin
            if (cv_ff[2*i+1] && (!cv_ff[2*i] || (ck_ff[2*i+1] < ck_ff[2*i]))) begin
               cv_in[i] = cv_ff[2*i+1];
               ck_in[i] = ck_ff[2*i+1];
               ci_in[i] = ci_ff[2*i+1];
            end else begin
               cv_in[i] = cv_ff[2*i];
               ck_in[i] = ck_ff[2*i];
               ci_in[i] = ci_ff[2*i];
            end
         end
         for (int i = Pow / 2; i < Pow; i++) begin
            cv_in[i] = 1'b0;
         end
      end
   end

   // update slots on an arrival or a tick
   always_comb begin
      for (int i = 0; i < MAX_PROCS; i++) begin
         present_in[i] = present_ff[i];
         remain_in[i]  = remain_ff[i];
         wait_in[i]    = wait_ff[i];
         turn_in[i]    = turn_ff[i];
      end
      if (cmd.exec_op && (req_ff.req_type == srtf_pkg::REQ_ARRIVAL) && in_range &&
          !present_ff[slot]) begin
         present_in[slot] = 1'b1;
         remain_in[slot]  = req_ff.burst_length;
         wait_in[slot]    = '0;
         turn_in[slot]    = '0;
      end
      if (cmd.apply_tick && cv_ff[0]) begin
         for (int i = 0; i < MAX_PROCS; i++) begin
            if (present_ff[i] && (remain_ff[i] != '0)) begin
               if (turn_ff[i] != '1) begin
                  turn_in[i] = turn_ff[i] + 1'b1;
               end
               if (IdxW'(i) == ci_ff[0]) begin
                  remain_in[i] = remain_ff[i] - 1'b1;
               end else if (wait_ff[i] != '1) begin
                  wait_in[i] = wait_ff[i] + 1'b1;
               end
            end
         end
      end
   end

   // build the result word
   always_comb begin
      rsp_in        = rsp_ff;
      last_valid_in = last_valid_ff;
      last_id_in    = last_id_ff;
      if (cmd.exec_op) begin
         rsp_in = '0;
         unique case (req_ff.req_type)
            srtf_pkg::REQ_ARRIVAL: begin
               rsp_in.rejected = !in_range || present_ff[slot];
            end
            srtf_pkg::REQ_STATS: begin
               if (slot_present) begin
                  rsp_in.wait_count = (wait_wide > OutMax) ? '1 : OW'(wait_wide);
                  rsp_in.turnaround_count = (turn_wide > OutMax) ? '1 : OW'(turn_wide);
               end
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end else if (cmd.apply_tick) begin
         rsp_in = '0;
         if (cv_ff[0]) begin
            rsp_in.running_id     = srtf_pkg::ID_W'(ci_ff[0]);
            rsp_in.newly_selected = !last_valid_ff || (last_id_ff != ci_ff[0]);
            rsp_in.finished       = (ck_ff[0] == BW'(1));
         end else begin
            rsp_in.idle = 1'b1;
         end
         last_valid_in = cv_ff[0];
         last_id_in    = ci_ff[0];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PROCS; i++) begin
            present_ff[i] <= 1'b0;
         end
         last_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < MAX_PROCS; i++) begin
            present_ff[i] <= present_in[i];
         end
         last_valid_ff <= last_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
         remain_ff[i] <= remain_in[i];
         wait_ff[i]   <= wait_in[i];
         turn_ff[i]   <= turn_in[i];
      end
      for (int i = 0; i < Pow; i++) begin
         cv_ff[i] <= cv_in[i];
         ck_ff[i] <= ck_in[i];
         ci_ff[i] <= ci_in[i];
      end
      if (cmd.load_req) begin
         req_ff <= req_word;
      end
      rsp_ff     <= rsp_in;
      last_id_ff <= last_id_in;
   end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the shortest-remaining-time scheduler: directed table and random traffic.
`default_nettype none

module tb;

   localparam int CLK_PERIOD     = 4;
   localparam int TIMEOUT_CYCLES = 300_000;
   localparam int NUM_SLOTS      = srtf_pkg::MAX_PROCS_DEF;
   localparam int NO_RUNNER      = NUM_SLOTS;
   localparam int CNT_W          = srtf_pkg::COUNT_BITS_DEF;
   localparam int RANDOM_PHASES  = 4;
   localparam int PHASE_ITEMS    = 350;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_LIMIT    = 100_000;
   localparam logic [srtf_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      srtf_pkg::req_word_type word;
      bit                     pinned;
      srtf_pkg::rsp_word_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   srtf_chan_if #(.word_type(srtf_pkg::req_word_type)) req_chan ();
   srtf_chan_if #(.word_type(srtf_pkg::rsp_word_type)) rsp_chan ();

   shortest_remaining_time_scheduler_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // scheduler state as predicted
   bit                          slot_present [NUM_SLOTS] = '{default: 1'b0};
   logic [srtf_pkg::BURST_W-1:0] slot_left   [NUM_SLOTS] = '{default: '0};
   logic [CNT_W-1:0]            slot_wait    [NUM_SLOTS] = '{default: '0};
   logic [CNT_W-1:0]            slot_turn    [NUM_SLOTS] = '{default: '0};
   int                          last_runner = NO_RUNNER;

   srtf_pkg::rsp_word_type due_results [$];
   stim_row_type           directed_rows [$];
   int                     fail_count = 0;

   // expectation pinned to the word on offer, typed in by the directed table
   bit                     pin_valid;
   srtf_pkg::rsp_word_type pin_want;

   // traffic shaping
   int snd_idle_pct  = 0;
   int rcv_stall_pct = 0;
   int hold_seq      = 0;

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // advance the predicted scheduler by one request word and return its result
   function automatic srtf_pkg::rsp_word_type schedule_step(input srtf_pkg::req_word_type w);
      srtf_pkg::rsp_word_type r;
      int best;
      r    = '0;
      best = NO_RUNNER;
      case (w.req_type)
         srtf_pkg::REQ_ARRIVAL: begin
            if (slot_present[w.proc_id]) begin
               r.rejected = 1'b1;
            end else begin
               slot_present[w.proc_id] = 1'b1;
               slot_left[w.proc_id]    = w.burst_length;
               slot_wait[w.proc_id]    = '0;
               slot_turn[w.proc_id]    = '0;
            end
         end
         srtf_pkg::REQ_TICK: begin
            // pick the least remaining burst, lowest slot on a tie
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_present[i] && slot_left[i] != '0 &&
                   (best == NO_RUNNER || slot_left[i] < slot_left[best]))
                  best = i;
            end
            if (best == NO_RUNNER) begin
               r.idle      = 1'b1;
               last_runner = NO_RUNNER;
            end else begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (slot_present[i] && slot_left[i] != '0) begin
                     slot_turn[i] = sat_inc(slot_turn[i]);
                     if (i != best)
                        slot_wait[i] = sat_inc(slot_wait[i]);
                  end
               end
               r.running_id     = srtf_pkg::ID_W'(best);
               r.newly_selected = (best != last_runner);
               slot_left[best]  = slot_left[best] - 1'b1;
               r.finished       = (slot_left[best] == '0);
               last_runner      = best;
            end
         end
         srtf_pkg::REQ_STATS: begin
            r.wait_count       = srtf_pkg::OUT_CNT_W'(slot_wait[w.proc_id]);
            r.turnaround_count = srtf_pkg::OUT_CNT_W'(slot_turn[w.proc_id]);
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic srtf_pkg::req_word_type mk_req(input logic [srtf_pkg::REQ_W-1:0] op,
                                                     input int id, input int burst);
      srtf_pkg::req_word_type w;
      w.req_type     = op;
      w.proc_id      = srtf_pkg::ID_W'(id);
      w.burst_length = srtf_pkg::BURST_W'(burst);
      return w;
   endfunction

   function automatic srtf_pkg::rsp_word_type make_rsp(input int id, input bit idl,
                                                       input bit nsel, input bit fin,
                                                       input bit rej);
      srtf_pkg::rsp_word_type r;
      r                = '0;
      r.running_id     = srtf_pkg::ID_W'(id);
      r.idle           = idl;
      r.newly_selected = nsel;
      r.finished       = fin;
      r.rejected       = rej;
      return r;
   endfunction

   function automatic void add_row(input logic [srtf_pkg::REQ_W-1:0] op, input int id,
                                   input int burst, input bit pinned,
                                   input srtf_pkg::rsp_word_type want);
      stim_row_type row;
      row.word   = mk_req(op, id, burst);
      row.pinned = pinned;
      row.want   = want;
      directed_rows.push_back(row);
   endfunction

   // mostly ticks, with arrivals, reads and the unused code mixed in
   function automatic srtf_pkg::req_word_type random_request();
      srtf_pkg::req_word_type w;
      int pick;
      w.proc_id      = srtf_pkg::ID_W'($urandom_range(NUM_SLOTS - 1));
      w.burst_length = srtf_pkg::BURST_W'($urandom_range(16'hFFFF));
      pick           = $urandom_range(99);
      if (pick < 50) begin
         w.req_type = srtf_pkg::REQ_TICK;
      end else if (pick < 70) begin
         w.req_type = srtf_pkg::REQ_STATS;
      end else if (pick < 95) begin
         w.req_type = srtf_pkg::REQ_ARRIVAL;
         case ($urandom_range(9))
            0:       w.burst_length = '0;
            1:       ;
            default: w.burst_length = srtf_pkg::BURST_W'($urandom_range(120, 1));
         endcase
      end else begin
         w.req_type = REQ_UNUSED;
      end
      return w;
   endfunction

   // offer one word, with an optional idle gap first, and hold it until taken
   task automatic send_word(input srtf_pkg::req_word_type w, input bit pinned,
                            input srtf_pkg::rsp_word_type want);
      if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= w;
      pin_valid        <= pinned;
      pin_want         <= want;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // stop offering and wait for every expected word to come back
   task automatic wait_drained();
      int n;
      n = 0;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
   endtask

   // compare result words in order, then record the expectation of an accepted request
   always @(posedge clock) begin : result_check
      srtf_pkg::rsp_word_type want;
      srtf_pkg::rsp_word_type predicted;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (due_results.size() == 0) begin
               report_error("result word with nothing expected");
            end else begin
               want = due_results.pop_front();
               if (rsp_chan.payload !== want)
                  report_error($sformatf("result word: got %h, expected %h",
                                         rsp_chan.payload, want));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            predicted = schedule_step(req_chan.payload);
            due_results.push_back(pin_valid ? pin_want : predicted);
         end
      end
   end

   // result port: random stalls, plus a long hold-off on request
   initial begin : result_sink
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rcv_stall_pct);
         end
      end
   end

   initial begin : stimulus
      srtf_pkg::rsp_word_type zero_rsp;
      zero_rsp = '0;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      pin_valid        <= 1'b0;
      pin_want         <= '0;
      reset            <= 1'b1;

      // directed table: reset state, extremes, duplicates, zero burst, preemption, ties
      add_row(srtf_pkg::REQ_STATS,   0,  0,        1'b1, zero_rsp);
      add_row(srtf_pkg::REQ_TICK,    0,  0,        1'b1,
              make_rsp(0, 1'b1, 1'b0, 1'b0, 1'b0));
      add_row(REQ_UNUSED,            15, 16'hFFFF, 1'b1, zero_rsp);
      add_row(srtf_pkg::REQ_ARRIVAL, 0,  3,        1'b1, zero_rsp);
      add_row(srtf_pkg::REQ_ARRIVAL, 0,  5,        1'b1,
              make_rsp(0, 1'b0, 1'b0, 1'b0, 1'b1));
      add_row(srtf_pkg::REQ_ARRIVAL, 15, 0,        1'b1, zero_rsp);
      add_row(srtf_pkg::REQ_ARRIVAL, 2,  2,        1'b1, zero_rsp);
      add_row(srtf_pkg::REQ_TICK,    0,  0,        1'b1,
              make_rsp(2, 1'b0, 1'b1, 1'b0, 1'b0));
      add_row(srtf_pkg::REQ_ARRIVAL, 1,  1,        1'b1, zero_rsp);
      add_row(srtf_pkg::REQ_TICK,    0,  0,        1'b0, zero_rsp);
      add_row(srtf_pkg::REQ_TICK,    0,  0,        1'b0, zero_rsp);
      add_row(srtf_pkg::REQ_ARRIVAL, 3,  3,        1'b1, zero_rsp);
      for (int i = 0; i < 6; i++)
         add_row(srtf_pkg::REQ_TICK, 0, 0, 1'b0, zero_rsp);
      add_row(srtf_pkg::REQ_TICK,    0,  0,        1'b1,
              make_rsp(0, 1'b1, 1'b0, 1'b0, 1'b0));
      add_row(srtf_pkg::REQ_STATS,   3,  0,        1'b0, zero_rsp);
      add_row(srtf_pkg::REQ_STATS,   15, 0,        1'b1, zero_rsp);
      add_row(srtf_pkg::REQ_STATS,   7,  0,        1'b1, zero_rsp);
      add_row(srtf_pkg::REQ_ARRIVAL, 15, 9,        1'b1,
              make_rsp(0, 1'b0, 1'b0, 1'b0, 1'b1));
      add_row(srtf_pkg::REQ_STATS,   0,  0,        1'b0, zero_rsp);
      add_row(srtf_pkg::REQ_TICK,    0,  0,        1'b1,
              make_rsp(0, 1'b1, 1'b0, 1'b0, 1'b0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].pinned, directed_rows[i].want);
      wait_drained();

      // random traffic under each idling mix
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       begin snd_idle_pct = 0;  rcv_stall_pct <= 0;  end
            1:       begin snd_idle_pct = 82; rcv_stall_pct <= 0;  end
            2:       begin snd_idle_pct = 0;  rcv_stall_pct <= 82; end
            default: begin snd_idle_pct = 27; rcv_stall_pct <= 27; end
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 0 && k == 150)
               hold_seq <= hold_seq + 1;
            send_word(random_request(), 1'b0, zero_rsp);
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (due_results.size() != 0)
         report_error($sformatf("%0d expected words never arrived", due_results.size()));
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/srtf_pkg.sv
rtl/core/srtf_chan_if.sv
rtl/core/srtf_ctrl.sv
rtl/core/srtf_dpath.sv
rtl/core/shortest_remaining_time_scheduler_core.sv
verif/tb.sv
